FILE: sv/sdfs_pkg.sv
package sdfs_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int MAX_DIRECTIONS = 64;
    localparam int MAX_FRAMES     = 4096;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 64;
    localparam int NORM_TOP     = 59;   // bit that the larger magnitude is scaled to

    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int TIME_W  = 48;
    localparam int TSUM_W  = TIME_W + 2;    // signed sum of time and offset
    localparam int TU_W    = TIME_W + 1;    // clamped local time
    localparam int RAW_W   = 50;            // raw frame number
    localparam int MOD_STEP   = 2;          // quotient bits resolved per stage
    localparam int MOD_STAGES = RAW_W / MOD_STEP;

    localparam int DC_W       = 7;
    localparam int FC_W       = 13;
    localparam int DIR_W      = 6;
    localparam int FRAME_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION_COUNT = 3'd0,
        REG_FRAME_COUNT     = 3'd1,
        REG_FRAME_RATE      = 3'd2,
        REG_PLAYBACK_SPEED  = 3'd3,
        REG_LOOP_ENABLE     = 3'd4,
        REG_PAUSE_ENABLE    = 3'd5
    } t_cfg_reg;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/sdfs_ifs.sv
interface sdfs_item_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_z;
    logic signed [31:0] actor_x;
    logic signed [31:0] actor_z;
    logic [15:0] actor_yaw;
    logic [47:0] time_now;
    logic signed [31:0] time_offset;

    modport source (output valid, cam_x, cam_z, actor_x, actor_z, actor_yaw,
                    time_now, time_offset, input ready);
    modport sink   (input valid, cam_x, cam_z, actor_x, actor_z, actor_yaw,
                    time_now, time_offset, output ready);
endinterface

interface sdfs_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  dir_sel;
    logic [11:0] frame_sel;

    modport source (output valid, dir_sel, frame_sel, input ready);
    modport sink   (input valid, dir_sel, frame_sel, output ready);
endinterface

interface sdfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/sdfs_cordic.sv
module sdfs_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [sdfs_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [sdfs_pkg::CORDIC_W-1:0] i_y,
    input  logic [31:0]                         i_ang,
    output logic [31:0]                         o_ang
);

    logic signed [sdfs_pkg::CORDIC_W-1:0] r_x [sdfs_pkg::CORDIC_STEPS];
    logic signed [sdfs_pkg::CORDIC_W-1:0] r_y [sdfs_pkg::CORDIC_STEPS];
    logic [31:0]                          r_a [sdfs_pkg::CORDIC_STEPS];

    // one vectoring micro-rotation per stage
    for (genvar g = 0; g < sdfs_pkg::CORDIC_STEPS; g++) begin : g_stage
        logic signed [sdfs_pkg::CORDIC_W-1:0] x_in;
        logic signed [sdfs_pkg::CORDIC_W-1:0] y_in;
        logic [31:0]                          a_in;

        if (g == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign a_in = i_ang;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign a_in = r_a[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[sdfs_pkg::CORDIC_W-1]) begin
                    r_x[g] <= x_in + (y_in >>> g);
                    r_y[g] <= y_in - (x_in >>> g);
                    r_a[g] <= a_in + sdfs_pkg::atan_turn(g);
                end else begin
                    r_x[g] <= x_in - (y_in >>> g);
                    r_y[g] <= y_in + (x_in >>> g);
                    r_a[g] <= a_in - sdfs_pkg::atan_turn(g);
                end
            end
        end
    end

    assign o_ang = r_a[sdfs_pkg::CORDIC_STEPS-1];

endmodule

FILE: sv/sdfs_mod.sv
module sdfs_mod (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sdfs_pkg::RAW_W-1:0]    i_raw,
    input  logic [sdfs_pkg::FC_W-1:0]     i_div,
    output logic [sdfs_pkg::FC_W-1:0]     o_rem
);

    // restoring remainder, MOD_STEP quotient bits per stage
    logic [sdfs_pkg::FC_W-1:0]  r_rem  [sdfs_pkg::MOD_STAGES];
    logic [sdfs_pkg::RAW_W-1:0] r_bits [sdfs_pkg::MOD_STAGES];

    for (genvar g = 0; g < sdfs_pkg::MOD_STAGES; g++) begin : g_stage
        logic [sdfs_pkg::FC_W-1:0]  rem_in;
        logic [sdfs_pkg::RAW_W-1:0] bits_in;
        logic [sdfs_pkg::FC_W-1:0]  n_rem;
        logic [sdfs_pkg::RAW_W-1:0] n_bits;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign bits_in = i_raw;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign bits_in = r_bits[g-1];
        end

        always_comb begin
            logic [sdfs_pkg::FC_W:0] t2;
            n_rem  = rem_in;
            n_bits = bits_in;
            for (int k = 0; k < sdfs_pkg::MOD_STEP; k++) begin
                t2 = {n_rem, n_bits[sdfs_pkg::RAW_W-1]};
                n_bits = n_bits << 1;
                if (t2 >= {1'b0, i_div}) begin
                    t2 = t2 - {1'b0, i_div};
                end
                n_rem = t2[sdfs_pkg::FC_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_bits[g] <= n_bits;
            end
        end
    end

    assign o_rem = r_rem[sdfs_pkg::MOD_STAGES-1];

endmodule

FILE: sv/sprite_direction_frame_select.sv
// Channel    Modport   Payload                                             Dir
// i_item     sink      cam_x/z, actor_x/z, actor_yaw, time_now, offset     in
// o_result   source    dir_sel, frame_sel                                  out
// i_cfg      sink      index, data (register write, always ready)          in
//
// One transaction per cycle sustained while o_result is not stalled; the depth is set by
// the 30-stage CORDIC plus the difference, leading-one, normalise and sector stages.
// The frame path runs a 25-stage remainder pipeline alongside the CORDIC.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// A stall on o_result freezes every stage at once; nothing is dropped or repeated.
module sprite_direction_frame_select (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdfs_item_if.sink            i_item,
    sdfs_result_if.source        o_result,
    sdfs_cfg_if.sink             i_cfg
);

    localparam int LAT     = 3 + sdfs_pkg::CORDIC_STEPS + 2;
    localparam int F_DONE  = 5 + sdfs_pkg::MOD_STAGES + 1;   // frame stage
    localparam int F_DLY   = LAT - F_DONE;
    localparam int AB      = sdfs_pkg::ANGLE_BITS;
    localparam int PROD_W  = AB + sdfs_pkg::DC_W;

    // ---------------- configuration registers ----------------
    logic [sdfs_pkg::DC_W-1:0] r_dir_count;
    logic [sdfs_pkg::FC_W-1:0] r_frame_count;
    logic [15:0]               r_frame_rate;
    logic [15:0]               r_speed;
    logic                      r_loop;
    logic                      r_pause;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_count   <= 7'd8;
            r_frame_count <= 13'd1;
            r_frame_rate  <= 16'd3072;
            r_speed       <= 16'd256;
            r_loop        <= 1'b1;
            r_pause       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (sdfs_pkg::t_cfg_reg'(i_cfg.index))
                sdfs_pkg::REG_DIRECTION_COUNT: r_dir_count   <= i_cfg.data[sdfs_pkg::DC_W-1:0];
                sdfs_pkg::REG_FRAME_COUNT:     r_frame_count <= i_cfg.data[sdfs_pkg::FC_W-1:0];
                sdfs_pkg::REG_FRAME_RATE:      r_frame_rate  <= i_cfg.data;
                sdfs_pkg::REG_PLAYBACK_SPEED:  r_speed       <= i_cfg.data;
                sdfs_pkg::REG_LOOP_ENABLE:     r_loop        <= i_cfg.data[0];
                sdfs_pkg::REG_PAUSE_ENABLE:    r_pause       <= i_cfg.data[0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // clamped counts
    logic [sdfs_pkg::DC_W-1:0] dcnt;
    logic [sdfs_pkg::FC_W-1:0] fcnt;
    logic [sdfs_pkg::FC_W-1:0] fcnt_m1;
    assign dcnt = (r_dir_count > sdfs_pkg::DC_W'(sdfs_pkg::MAX_DIRECTIONS))
                ? sdfs_pkg::DC_W'(sdfs_pkg::MAX_DIRECTIONS) : r_dir_count;
    assign fcnt = (r_frame_count > sdfs_pkg::FC_W'(sdfs_pkg::MAX_FRAMES))
                ? sdfs_pkg::FC_W'(sdfs_pkg::MAX_FRAMES) : r_frame_count;
    assign fcnt_m1 = fcnt - 1'b1;

    // ---------------- pipeline control ----------------
    logic [LAT-1:0] r_vld;
    logic           adv;

    // whole pipe moves unless the output register holds an untaken result
    assign adv          = !r_vld[LAT-1] || o_result.ready;
    assign i_item.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_item.valid};
        end
    end

    // ---------------- stage 1: differences, time sum, rate product ----------------
    logic signed [sdfs_pkg::DIFF_W-1:0] r_a_dx, r_a_dz;
    logic signed [sdfs_pkg::TSUM_W-1:0] r_a_t;
    logic [31:0]                        r_a_p;
    logic [15:0]                        r_a_yaw;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_dx  <= {i_item.cam_x[31], i_item.cam_x}
                     - {i_item.actor_x[31], i_item.actor_x};
            r_a_dz  <= {i_item.cam_z[31], i_item.cam_z}
                     - {i_item.actor_z[31], i_item.actor_z};
            r_a_t   <= $signed({2'b00, i_item.time_now})
                     + $signed({{(sdfs_pkg::TSUM_W-32){i_item.time_offset[31]}},
                                i_item.time_offset});
            r_a_p   <= r_frame_rate * r_speed;
            r_a_yaw <= i_item.actor_yaw;
        end
    end

    // ---------------- stage 2: leading one, time clamp ----------------
    logic [sdfs_pkg::DIFF_W-1:0] abs_dx, abs_dz, mag;
    logic [5:0]                  top;

    assign abs_dx = r_a_dx[sdfs_pkg::DIFF_W-1] ? sdfs_pkg::DIFF_W'(-r_a_dx) : r_a_dx;
    assign abs_dz = r_a_dz[sdfs_pkg::DIFF_W-1] ? sdfs_pkg::DIFF_W'(-r_a_dz) : r_a_dz;
    assign mag    = abs_dx | abs_dz;

    always_comb begin
        top = '0;
        for (int i = 0; i < sdfs_pkg::DIFF_W; i++) begin
            if (mag[i]) begin
                top = 6'(i);
            end
        end
    end

    logic signed [sdfs_pkg::DIFF_W-1:0] r_b_dx, r_b_dz;
    logic [5:0]                         r_b_sh;
    logic                               r_b_zero;
    logic [sdfs_pkg::TU_W-1:0]          r_b_tu;
    logic [31:0]                        r_b_p;
    logic [15:0]                        r_b_yaw;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_dx   <= r_a_dx;
            r_b_dz   <= r_a_dz;
            r_b_sh   <= 6'(sdfs_pkg::NORM_TOP) - top;
            r_b_zero <= (mag == '0);
            r_b_tu   <= r_a_t[sdfs_pkg::TSUM_W-1] ? '0 : r_a_t[sdfs_pkg::TU_W-1:0];
            r_b_p    <= r_a_p;
            r_b_yaw  <= r_a_yaw;
        end
    end

    // ---------------- stage 3: normalise, half turn, low product ----------------
    logic signed [sdfs_pkg::CORDIC_W-1:0] sx, sy;
    assign sx = $signed({{(sdfs_pkg::CORDIC_W-sdfs_pkg::DIFF_W){r_b_dz[sdfs_pkg::DIFF_W-1]}},
                         r_b_dz}) <<< r_b_sh;
    assign sy = $signed({{(sdfs_pkg::CORDIC_W-sdfs_pkg::DIFF_W){r_b_dx[sdfs_pkg::DIFF_W-1]}},
                         r_b_dx}) <<< r_b_sh;

    logic signed [sdfs_pkg::CORDIC_W-1:0] r_c_x, r_c_y;
    logic [31:0]                          r_c_ang;
    logic [63:0]                          r_c_lo;
    logic [sdfs_pkg::TU_W-33:0]           r_c_thi;
    logic [31:0]                          r_c_p;
    logic                                 r_c_zero;
    logic [15:0]                          r_c_yaw;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_b_dz[sdfs_pkg::DIFF_W-1]) begin
                r_c_x   <= -sx;
                r_c_y   <= -sy;
                r_c_ang <= 32'h8000_0000;
            end else begin
                r_c_x   <= sx;
                r_c_y   <= sy;
                r_c_ang <= '0;
            end
            r_c_lo   <= r_b_tu[31:0] * r_b_p;
            r_c_thi  <= r_b_tu[sdfs_pkg::TU_W-1:32];
            r_c_p    <= r_b_p;
            r_c_zero <= r_b_zero;
            r_c_yaw  <= r_b_yaw;
        end
    end

    // ---------------- stages 4..33: CORDIC ----------------
    logic [31:0] bearing;

    sdfs_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_c_x),
        .i_y   (r_c_y),
        .i_ang (r_c_ang),
        .o_ang (bearing)
    );

    logic [16:0] r_dside [sdfs_pkg::CORDIC_STEPS];   // {zero, yaw}
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dside[0] <= {r_c_zero, r_c_yaw};
            for (int i = 1; i < sdfs_pkg::CORDIC_STEPS; i++) begin
                r_dside[i] <= r_dside[i-1];
            end
        end
    end

    // ---------------- stages 34..35: sector ----------------
    logic [31:0]   b_sum, y_sum;
    logic [AB-1:0] rel;
    assign b_sum = bearing + 32'(1 << (31 - AB));
    assign y_sum = {r_dside[sdfs_pkg::CORDIC_STEPS-1][15:0], 16'd0} + 32'(1 << (31 - AB));
    assign rel   = b_sum[31:32-AB] - y_sum[31:32-AB];

    logic [PROD_W-1:0] r_m;
    logic              r_m_zero;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m      <= PROD_W'(rel) * PROD_W'(dcnt) + PROD_W'(1 << (AB - 1));
            r_m_zero <= r_dside[sdfs_pkg::CORDIC_STEPS-1][16];
        end
    end

    logic [sdfs_pkg::DC_W-1:0]  sector;
    logic [sdfs_pkg::DIR_W-1:0] r_dir;
    assign sector = r_m[PROD_W-1:AB];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // rounding up to the count itself wraps to sector zero
            if (dcnt <= 7'd1 || r_m_zero || sector == dcnt) begin
                r_dir <= '0;
            end else begin
                r_dir <= sector[sdfs_pkg::DIR_W-1:0];
            end
        end
    end

    // ---------------- stages 4..5: frame product ----------------
    logic [sdfs_pkg::TU_W:0]   r_d_hi;
    logic [31:0]               r_d_lot;
    logic [sdfs_pkg::RAW_W-1:0] r_e_raw;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_hi  <= r_c_thi * r_c_p;
            r_d_lot <= r_c_lo[63:32];
            r_e_raw <= sdfs_pkg::RAW_W'(r_d_hi) + sdfs_pkg::RAW_W'(r_d_lot);
        end
    end

    // ---------------- stages 6..30: remainder, hold value alongside ----------------
    logic [sdfs_pkg::FC_W-1:0] rem;

    sdfs_mod u_mod (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_raw (r_e_raw),
        .i_div (fcnt),
        .o_rem (rem)
    );

    logic [sdfs_pkg::FRAME_W-1:0] sat;
    assign sat = (r_e_raw < sdfs_pkg::RAW_W'(fcnt_m1))
               ? r_e_raw[sdfs_pkg::FRAME_W-1:0] : fcnt_m1[sdfs_pkg::FRAME_W-1:0];

    logic [sdfs_pkg::FRAME_W-1:0] r_fside [sdfs_pkg::MOD_STAGES];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fside[0] <= sat;
            for (int i = 1; i < sdfs_pkg::MOD_STAGES; i++) begin
                r_fside[i] <= r_fside[i-1];
            end
        end
    end

    // ---------------- stage 31: frame select, then align with direction ----------------
    logic                         f_zero;
    logic [sdfs_pkg::FRAME_W-1:0] r_fd [F_DLY+1];

    assign f_zero = r_pause || r_frame_rate == '0 || r_speed == '0 || fcnt <= 13'd1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (f_zero) begin
                r_fd[0] <= '0;
            end else if (r_loop) begin
                r_fd[0] <= rem[sdfs_pkg::FRAME_W-1:0];
            end else begin
                r_fd[0] <= r_fside[sdfs_pkg::MOD_STAGES-1];
            end
            for (int i = 1; i <= F_DLY; i++) begin
                r_fd[i] <= r_fd[i-1];
            end
        end
    end

    assign o_result.valid     = r_vld[LAT-1];
    assign o_result.dir_sel   = r_dir;
    assign o_result.frame_sel = r_fd[F_DLY];

    // ---------------- checks ----------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] && !o_result.ready |-> !i_item.ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_vld[0])
        else $error("accepted transaction not in first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

    a_bubble_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_vld[LAT-2] |=> !o_result.valid)
        else $error("result appeared from an empty stage");

endmodule
